// File: hw/rtl/czp_pkg.sv
package czp_pkg;

   // Central directory file header signature, bytes 50 4B 01 02 on the wire.
   localparam logic [31:0] CD_SIGNATURE = 32'h02014b50;

   // Byte offsets inside the 46-byte central directory file header.
   localparam logic [5:0] HDR_FIRST_POS   = 6'd4;
   localparam logic [5:0] CRC_POS         = 6'd16;
   localparam logic [5:0] NAME_LEN_POS    = 6'd28;
   localparam logic [5:0] EXTRA_LEN_POS   = 6'd30;
   localparam logic [5:0] COMMENT_LEN_POS = 6'd32;
   localparam logic [5:0] HDR_LAST_POS    = 6'd45;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  name_byte;
      logic [31:0] entry_crc;
      logic        name_last;
      logic        name_empty;
   } rsp_payload_type;

   // One registered input byte handed to the parser for this cycle.
   typedef struct packed {
      logic            valid;
      req_payload_type payload;
   } step_type;

   // Result of one parser step, if any.
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

endpackage

// File: hw/rtl/czp_stream_if.sv
interface czp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/czp_in_stage.sv
module czp_in_stage
   import czp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   czp_stream_if.sink    req_if,
   input  logic          advance,
   output step_type      step
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_payload_ff;
   logic            load;

   // The register may take a new byte when it is empty or its byte moves on now.
   assign req_if.ready = !in_valid_ff || advance;
   assign load         = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (load) begin
         in_payload_ff <= req_if.payload;
      end
   end

   assign step.valid   = in_valid_ff && advance;
   assign step.payload = in_payload_ff;

endmodule

// File: hw/rtl/czp_parser.sv
module czp_parser
   import czp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  step_type   step,
   output result_type result
);

   typedef enum logic [1:0] {
      PH_SCAN,
      PH_HEADER,
      PH_NAME,
      PH_SKIP
   } phase_type;

   phase_type   phase_ff,    phase_in;
   logic [23:0] window_ff,   window_in;
   logic [1:0]  fill_ff,     fill_in;
   logic [5:0]  pos_ff,      pos_in;
   logic [31:0] crc_ff,      crc_in;
   logic [15:0] name_len_ff, name_len_in;
   logic [16:0] skip_ff,     skip_in;
   logic [16:0] left_ff,     left_in;
   logic [16:0] left_dec;
   logic [7:0]  b;

   assign b        = step.payload.data_byte;
   assign left_dec = left_ff - 17'd1;

   always_comb begin
      phase_in    = phase_ff;
      window_in   = window_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      name_len_in = name_len_ff;
      skip_in     = skip_ff;
      left_in     = left_ff;

      result.valid              = 1'b0;
      result.payload.name_byte  = b;
      result.payload.entry_crc  = crc_ff;
      result.payload.name_last  = 1'b0;
      result.payload.name_empty = 1'b0;

      unique case (phase_ff)
         PH_SCAN: begin
            // The window holds the three previous bytes; the new byte completes it.
            window_in = {b, window_ff[23:8]};
            if (fill_ff != 2'd3) begin
               fill_in = fill_ff + 2'd1;
            end
            if (fill_ff == 2'd3 && {b, window_ff} == CD_SIGNATURE) begin
               phase_in = PH_HEADER;
               pos_in   = HDR_FIRST_POS;
               crc_in   = '0;
            end
         end
         PH_HEADER: begin
            case (pos_ff)
               CRC_POS:                 crc_in[7:0]        = b;
               CRC_POS + 6'd1:          crc_in[15:8]       = b;
               CRC_POS + 6'd2:          crc_in[23:16]      = b;
               CRC_POS + 6'd3:          crc_in[31:24]      = b;
               NAME_LEN_POS:            name_len_in[7:0]   = b;
               NAME_LEN_POS + 6'd1:     name_len_in[15:8]  = b;
               EXTRA_LEN_POS:           skip_in            = {9'd0, b};
               EXTRA_LEN_POS + 6'd1:    skip_in[15:8]      = b;
               // The low comment-length byte waits in the down counter.
               COMMENT_LEN_POS:         left_in            = {9'd0, b};
               COMMENT_LEN_POS + 6'd1: begin
                  skip_in = skip_ff + {1'b0, b, left_ff[7:0]};
                  left_in = '0;
               end
               default: ;
            endcase
            pos_in = pos_ff + 6'd1;
            if (pos_ff == HDR_LAST_POS) begin
               pos_in = '0;
               if (name_len_ff == '0) begin
                  result.valid              = step.valid;
                  result.payload.name_byte  = '0;
                  result.payload.name_last  = 1'b1;
                  result.payload.name_empty = 1'b1;
                  if (skip_ff == '0) begin
                     phase_in = PH_SCAN;
                     fill_in  = '0;
                  end else begin
                     left_in  = skip_ff;
                     phase_in = PH_SKIP;
                  end
               end else begin
                  left_in  = {1'b0, name_len_ff};
                  phase_in = PH_NAME;
               end
            end
         end
         PH_NAME: begin
            left_in                  = left_dec;
            result.valid             = step.valid;
            result.payload.name_last = (left_dec == '0);
            if (left_dec == '0) begin
               if (skip_ff == '0) begin
                  phase_in = PH_SCAN;
                  fill_in  = '0;
               end else begin
                  left_in  = skip_ff;
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_SCAN;
               fill_in  = '0;
            end
         end
      endcase

      // The final directory byte drops any entry still in progress.
      if (step.payload.last_byte) begin
         phase_in = PH_SCAN;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SCAN;
         fill_ff  <= '0;
      end else if (step.valid) begin
         phase_ff    <= phase_in;
         fill_ff     <= fill_in;
         window_ff   <= window_in;
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         name_len_ff <= name_len_in;
         skip_ff     <= skip_in;
         left_ff     <= left_in;
      end
   end

endmodule

// File: hw/rtl/czp_out_stage.sv
module czp_out_stage
   import czp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  result_type    result,
   czp_stream_if.source  rsp_if,
   output logic          advance
);

   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_payload_ff;

   // The register is free when empty or when its result transfers this cycle.
   assign advance = !out_valid_ff || rsp_if.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && result.valid) begin
         out_payload_ff <= result.payload;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_payload_ff;

endmodule

// File: hw/rtl/zip_central_directory_parser.sv
// Parses a zip central directory streamed in one byte per transfer on req_if and
// returns one rsp_if transfer per file-name byte of every central directory file
// header found (signature 0x02014b50), each tagged with that entry's CRC-32 and
// flagged on the last name byte; an entry with an empty name gives a single
// transfer with name_empty set. Extra fields, comments and bytes between
// headers produce nothing, and last_byte ends the directory, dropping an entry
// that is cut off. The block takes one byte every clock cycle unless held back as
// described below; a byte passes an input register and the parser into the result
// register, which offers its result on rsp_if. Input is held back only while the
// result register is full and rsp_if.ready is low.
module zip_central_directory_parser
   import czp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   czp_stream_if.sink    req_if,
   czp_stream_if.source  rsp_if
);

   step_type   step;
   result_type result;
   logic       advance;

   czp_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .advance (advance),
      .step    (step)
   );

   czp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (result)
   );

   czp_out_stage u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .result  (result),
      .rsp_if  (rsp_if),
      .advance (advance)
   );

endmodule

// File: hw/rtl/czp_checker.sv
module czp_checker
   import czp_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // A result waiting on the output side stays until it transfers.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   // Input is held back only by a full, stalled result register.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.name_empty |->
         rsp_payload.name_last && rsp_payload.name_byte == 8'd0)
      else $error("empty-name result not marked as a zero final byte");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

endmodule

bind zip_central_directory_parser czp_checker u_czp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
